@@ design/hbm_pkg.sv @@
// ----------------------------------------------------------------------------
// hbm_pkg
// shared constants and codes of the heartbeat liveness monitor
// ----------------------------------------------------------------------------
package hbm_pkg;

    localparam int NODE_COUNT_DEF = 63;

    localparam int OPC_W     = 2;
    localparam int NODE_W    = 6;
    localparam int TIME_W    = 32;
    localparam int TMO_W     = 16;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = 6;
    localparam int NODE_CMP_W = 8;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [CNT_W-1:0] DEAD_MAX      = 6'd63;
    localparam logic [CNT_W-1:0] MAX_DEATHS    = 6'd63;

    localparam logic [OPC_W-1:0] OP_HEARTBEAT = 2'd0;
    localparam logic [OPC_W-1:0] OP_READY     = 2'd1;
    localparam logic [OPC_W-1:0] OP_SCAN      = 2'd2;

    localparam logic [KIND_W-1:0] EV_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] EV_ALIVE = 2'd1;
    localparam logic [KIND_W-1:0] EV_DEAD  = 2'd2;
    localparam logic [KIND_W-1:0] EV_DONE  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

@@ design/hbm_time_ram.sv @@
// ----------------------------------------------------------------------------
// hbm_time_ram
// last-seen time store, one write port, one registered read port
// ----------------------------------------------------------------------------
module hbm_time_ram #(
    parameter int DEPTH  = 63,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

@@ design/node_heartbeat_liveness_monitor_core.sv @@
// ----------------------------------------------------------------------------
// node_heartbeat_liveness_monitor_core
// heartbeat timeout monitor for up to NODE_COUNT bus nodes
// ----------------------------------------------------------------------------
// input channel (i_valid / o_ready) carries one request: heartbeat, ready or
// timeout scan. output channel (o_valid / i_ready) carries result items, the
// final one of each request flagged by o_last.
// heartbeat / ready: one result, computed in the exec state once the output
// register is free and then held there; the next request is taken once the
// core is back in idle.
// scan: walks the node table one entry per cycle through the time memory,
// except while a death item waits on a stalled receiver; the walk ends after
// the last entry or after MAX_DEATHS deaths, and the done item follows it.
// one request at a time: o_ready is high only when the previous request is
// fully handled; its last result may still wait in the output register.
// when the receiver stalls, the walk holds on an entry that has expired.
// reset clears the liveness flags, the dead count and the warning and sets
// the timeout to 3000 ms; the time memory needs no clearing, entries are
// read only for alive nodes. timeout writes are taken at any time.
// ----------------------------------------------------------------------------
module node_heartbeat_liveness_monitor_core #(
    parameter int NODE_COUNT = hbm_pkg::NODE_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [hbm_pkg::TMO_W-1:0]   i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hbm_pkg::OPC_W-1:0]   i_opcode,
    input  logic [hbm_pkg::NODE_W-1:0]  i_node_id,
    input  logic [hbm_pkg::TIME_W-1:0]  i_now_ms,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hbm_pkg::KIND_W-1:0]  o_event_kind,
    output logic [hbm_pkg::NODE_W-1:0]  o_event_node,
    output logic                        o_sync_request,
    output logic                        o_warning,
    output logic [hbm_pkg::CNT_W-1:0]   o_dead_total,
    output logic                        o_last
);
    import hbm_pkg::*;

    localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NODE_COUNT - 1);

    t_state r_state, n_state;

    logic [TMO_W-1:0]      r_timeout;
    logic [OPC_W-1:0]      r_opcode;
    logic [NODE_W-1:0]     r_node;
    logic [TIME_W-1:0]     r_now;
    logic [NODE_COUNT-1:0] r_alive, n_alive;
    logic [NODE_COUNT-1:0] r_seen, n_seen;
    logic [CNT_W-1:0]      r_dead_cnt, n_dead_cnt;
    logic                  r_warning, n_warning;
    logic [IW-1:0]         r_idx, n_idx;
    logic [CNT_W-1:0]      r_deaths, n_deaths;

    logic                  r_out_valid, n_out_valid;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [NODE_W-1:0]     r_ev_node, n_ev_node;
    logic                  r_sync, n_sync;
    logic                  r_out_warn, n_out_warn;
    logic [CNT_W-1:0]      r_out_dead, n_out_dead;
    logic                  r_last, n_last;

    logic                  out_free;
    logic                  node_ok;
    logic [IW-1:0]         hb_idx;
    logic                  was_alive;
    logic                  was_dead;
    logic                  mem_we;
    logic [IW-1:0]         rd_addr;
    logic [TIME_W-1:0]     rd_data;
    logic [TIME_W-1:0]     age;
    logic                  expired;
    logic [IW:0]           idx_p1;

    hbm_time_ram #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (IW),
        .DATA_W (TIME_W)
    ) u_time_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (hb_idx),
        .i_wr_data (r_now),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_ready;
    assign node_ok  = (r_node != '0) &&
                      ({{(NODE_CMP_W-NODE_W){1'b0}}, r_node} <= NODE_CMP_W'(NODE_COUNT));
    assign hb_idx    = IW'(r_node - NODE_W'(1));
    assign was_alive = r_alive[hb_idx];
    assign was_dead  = r_seen[hb_idx] && !r_alive[hb_idx];
    assign age       = r_now - rd_data;
    assign expired   = r_alive[r_idx] && (age > {{(TIME_W-TMO_W){1'b0}}, r_timeout});
    assign idx_p1    = {1'b0, r_idx} + (IW+1)'(1);

    always_comb begin
        n_state     = r_state;
        n_alive     = r_alive;
        n_seen      = r_seen;
        n_dead_cnt  = r_dead_cnt;
        n_warning   = r_warning;
        n_idx       = r_idx;
        n_deaths    = r_deaths;
        n_out_valid = r_out_valid && !i_ready;
        n_kind      = r_kind;
        n_ev_node   = r_ev_node;
        n_sync      = r_sync;
        n_out_warn  = r_out_warn;
        n_out_dead  = r_out_dead;
        n_last      = r_last;
        mem_we      = 1'b0;
        rd_addr     = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_opcode == OP_SCAN) begin
                    rd_addr  = '0;
                    n_idx    = '0;
                    n_deaths = '0;
                    n_state  = S_SCAN;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    if ((r_opcode == OP_HEARTBEAT || r_opcode == OP_READY) && node_ok) begin
                        mem_we          = 1'b1;
                        n_alive[hb_idx] = 1'b1;
                        n_seen[hb_idx]  = 1'b1;
                        if (!was_alive && was_dead && r_dead_cnt != '0) begin
                            n_dead_cnt = r_dead_cnt - CNT_W'(1);
                            if (n_dead_cnt == '0) begin
                                n_warning = 1'b0;
                            end
                        end
                        n_kind    = was_alive ? EV_NONE : EV_ALIVE;
                        n_ev_node = r_node;
                        n_sync    = (r_opcode == OP_READY) || !was_alive;
                    end else begin
                        n_kind    = EV_NONE;
                        n_ev_node = '0;
                        n_sync    = 1'b0;
                    end
                    n_out_warn = n_warning;
                    n_out_dead = n_dead_cnt;
                end
            end
            S_SCAN: begin
                if (expired && !out_free) begin
                    rd_addr = r_idx;
                end else begin
                    rd_addr = IW'(idx_p1);
                    n_idx   = IW'(idx_p1);
                    if (expired) begin
                        n_alive[r_idx] = 1'b0;
                        if (r_dead_cnt < DEAD_MAX) begin
                            n_dead_cnt = r_dead_cnt + CNT_W'(1);
                        end
                        n_warning   = 1'b1;
                        n_deaths    = r_deaths + CNT_W'(1);
                        n_out_valid = 1'b1;
                        n_kind      = EV_DEAD;
                        n_ev_node   = NODE_W'(idx_p1);
                        n_sync      = 1'b0;
                        n_out_warn  = 1'b1;
                        n_out_dead  = n_dead_cnt;
                        n_last      = 1'b0;
                    end
                    if (r_idx == LAST_IDX || n_deaths == MAX_DEATHS) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = EV_DONE;
                    n_ev_node   = '0;
                    n_sync      = 1'b0;
                    n_out_warn  = r_warning;
                    n_out_dead  = r_dead_cnt;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeout   <= TIMEOUT_RESET;
            r_alive     <= '0;
            r_seen      <= '0;
            r_dead_cnt  <= '0;
            r_warning   <= 1'b0;
            r_idx       <= '0;
            r_deaths    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_alive     <= n_alive;
            r_seen      <= n_seen;
            r_dead_cnt  <= n_dead_cnt;
            r_warning   <= n_warning;
            r_idx       <= n_idx;
            r_deaths    <= n_deaths;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_opcode <= i_opcode;
            r_node   <= i_node_id;
            r_now    <= i_now_ms;
        end
        r_kind     <= n_kind;
        r_ev_node  <= n_ev_node;
        r_sync     <= n_sync;
        r_out_warn <= n_out_warn;
        r_out_dead <= n_out_dead;
        r_last     <= n_last;
    end

    assign o_valid        = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_event_node   = r_ev_node;
    assign o_sync_request = r_sync;
    assign o_warning      = r_out_warn;
    assign o_dead_total   = r_out_dead;
    assign o_last         = r_last;

    a_warn_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_warning == (r_dead_cnt != '0))
        else $error("warning flag out of step with dead count");

    a_scan_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_deaths < MAX_DEATHS))
        else $error("scan continued past death limit");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_kind == EV_DONE || o_event_kind == EV_NONE ||
                     o_event_kind == EV_ALIVE)) |-> o_last)
        else $error("single or done result without last");

    a_dead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == EV_DEAD) |-> (!o_last && o_warning))
        else $error("death item with last or without warning");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the heartbeat liveness monitor core: heartbeat,
// ready and scan requests are driven with random gaps on both channels, and
// every result item is checked against an in-bench tracker of node liveness
// ----------------------------------------------------------------------------
module testbench;
    import hbm_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] node;
        logic              sync;
        logic              warn;
        logic [CNT_W-1:0]  dead;
        logic              last;
    } t_liveness_event;

    class t_liveness_scoreboard;
        bit                alive[NODE_COUNT_DEF];
        bit                seen[NODE_COUNT_DEF];
        logic [TIME_W-1:0] last_seen[NODE_COUNT_DEF];
        logic [CNT_W-1:0]  dead_count;
        bit                warning;
        logic [TMO_W-1:0]  timeout;
        t_liveness_event   expected_events[$];
        int                failures;

        function new();
            foreach (alive[i]) begin
                alive[i]     = 1'b0;
                seen[i]      = 1'b0;
                last_seen[i] = '0;
            end
            dead_count = '0;
            warning    = 1'b0;
            timeout    = TIMEOUT_RESET;
            failures   = 0;
        endfunction

        function void set_timeout(logic [TMO_W-1:0] value);
            timeout = value;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void add_event(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] node,
                                logic sync, logic last);
            t_liveness_event ev;
            ev.kind = kind;
            ev.node = node;
            ev.sync = sync;
            ev.warn = warning;
            ev.dead = dead_count;
            ev.last = last;
            expected_events.push_back(ev);
        endfunction

        // tracks node liveness and queues the result items of one request
        function void note_request(logic [OPC_W-1:0] op, logic [NODE_W-1:0] node,
                                   logic [TIME_W-1:0] now);
            int                idx;
            bit                was_alive;
            bit                was_dead;
            int                deaths;
            logic [TIME_W-1:0] age;
            if (op == OP_HEARTBEAT || op == OP_READY) begin
                if (node == 0 || node > NODE_COUNT_DEF) begin
                    add_event(EV_NONE, '0, 1'b0, 1'b1);
                    return;
                end
                idx       = node - 1;
                was_alive = alive[idx];
                was_dead  = seen[idx] && !alive[idx];
                alive[idx]     = 1'b1;
                seen[idx]      = 1'b1;
                last_seen[idx] = now;
                if (!was_alive && was_dead && dead_count > 0) begin
                    dead_count = dead_count - 1'b1;
                    if (dead_count == 0)
                        warning = 1'b0;
                end
                add_event(was_alive ? EV_NONE : EV_ALIVE, node,
                          (op == OP_READY) || !was_alive, 1'b1);
            end else if (op == OP_SCAN) begin
                deaths = 0;
                for (int i = 0; i < NODE_COUNT_DEF && deaths < MAX_DEATHS; i++) begin
                    age = now - last_seen[i];
                    if (alive[i] && age > {16'd0, timeout}) begin
                        alive[i] = 1'b0;
                        if (dead_count < DEAD_MAX)
                            dead_count = dead_count + 1'b1;
                        warning = 1'b1;
                        add_event(EV_DEAD, NODE_W'(i + 1), 1'b0, 1'b0);
                        deaths++;
                    end
                end
                add_event(EV_DONE, '0, 1'b0, 1'b1);
            end else begin
                add_event(EV_NONE, '0, 1'b0, 1'b1);
            end
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_event(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] node,
                                  logic sync, logic warn, logic [CNT_W-1:0] dead,
                                  logic last);
            t_liveness_event want;
            if (expected_events.size() == 0) begin
                $error("result with nothing pending: kind %0d node %0d", kind, node);
                failures++;
                return;
            end
            want = expected_events.pop_front();
            compare("event_kind", want.kind, kind);
            compare("event_node", want.node, node);
            compare("sync_request", want.sync, sync);
            compare("warning", want.warn, warn);
            compare("dead_total", want.dead, dead);
            compare("last", want.last, last);
        endfunction
    endclass

    localparam logic [OPC_W-1:0] OP_UNUSED   = 2'd3;
    localparam int               STALL_LIMIT = 2000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [TMO_W-1:0]   i_cfg_wr_data = '0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic [OPC_W-1:0]   i_opcode      = '0;
    logic [NODE_W-1:0]  i_node_id     = '0;
    logic [TIME_W-1:0]  i_now_ms      = '0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [KIND_W-1:0]  o_event_kind;
    logic [NODE_W-1:0]  o_event_node;
    logic               o_sync_request;
    logic               o_warning;
    logic [CNT_W-1:0]   o_dead_total;
    logic               o_last;

    t_liveness_scoreboard sb;
    bit                 calm = 1'b0;
    int unsigned        timeout_now = TIMEOUT_RESET;
    logic [TIME_W-1:0]  bus_time = '0;
    int                 quiet_cycles = 0;

    node_heartbeat_liveness_monitor_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_node_id      (i_node_id),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_kind   (o_event_kind),
        .o_event_node   (o_event_node),
        .o_sync_request (o_sync_request),
        .o_warning      (o_warning),
        .o_dead_total   (o_dead_total),
        .o_last         (o_last)
    );

    always #4 i_clk = ~i_clk;

    // result side: check each accepted item, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_event(o_event_kind, o_event_node, o_sync_request,
                           o_warning, o_dead_total, o_last);
        i_ready <= calm || ($urandom_range(0, 99) >= 17);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_valid && i_ready) || (i_valid && o_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_request(input logic [OPC_W-1:0] op,
                                input logic [NODE_W-1:0] node,
                                input logic [TIME_W-1:0] now);
        while (!calm && $urandom_range(0, 99) < 17) begin
            i_valid   <= 1'b0;
            i_opcode  <= OPC_W'($urandom());
            i_node_id <= NODE_W'($urandom());
            i_now_ms  <= $urandom();
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_node_id <= node;
        i_now_ms  <= now;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(op, node, now);
    endtask

    task automatic drain_requests();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(input int unsigned value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= TMO_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_timeout(TMO_W'(value));
        timeout_now = value;
    endtask

    // every node reports in, then one scan takes them all down
    task automatic wake_all_nodes();
        int order[NODE_COUNT_DEF];
        int j;
        int t;
        foreach (order[i])
            order[i] = i + 1;
        foreach (order[i]) begin
            j        = $urandom_range(0, NODE_COUNT_DEF - 1);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i])
            push_request(($urandom_range(0, 1) == 0) ? OP_HEARTBEAT : OP_READY,
                         NODE_W'(order[i]), bus_time);
        bus_time = bus_time + timeout_now + 1 + $urandom_range(0, 3);
        push_request(OP_SCAN, NODE_W'($urandom()), bus_time);
    endtask

    task automatic random_traffic(input int count);
        int unsigned       pick;
        logic [NODE_W-1:0] node;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                push_request(OP_UNUSED, NODE_W'($urandom()), $urandom());
            end else if (pick < 9) begin
                push_request(pick[0] ? OP_READY : OP_HEARTBEAT, '0, bus_time);
            end else if (pick < 28) begin
                if ($urandom_range(0, 19) == 0)
                    bus_time = $urandom();
                else
                    bus_time = bus_time + $urandom_range(0, 2 * timeout_now + 2);
                push_request(OP_SCAN, NODE_W'($urandom()), bus_time);
            end else begin
                bus_time = bus_time + $urandom_range(0, timeout_now / 4 + 1);
                if ($urandom_range(0, 9) < 7)
                    node = NODE_W'($urandom_range(1, 12));
                else
                    node = NODE_W'($urandom_range(1, NODE_COUNT_DEF));
                push_request(($urandom_range(0, 3) == 0) ? OP_READY : OP_HEARTBEAT,
                             node, bus_time);
            end
        end
    endtask

    int unsigned phase_timeouts[5];

    initial begin
        sb = new();
        phase_timeouts[0] = 0;
        phase_timeouts[1] = 1;
        phase_timeouts[2] = 65535;
        phase_timeouts[3] = $urandom_range(2, 200);
        phase_timeouts[4] = $urandom_range(1000, 20000);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset timeout
        push_request(OP_SCAN, '0, 32'd0);
        push_request(OP_HEARTBEAT, 6'd1, 32'd0);
        push_request(OP_HEARTBEAT, 6'd1, 32'd100);
        push_request(OP_READY, 6'd1, 32'd200);
        push_request(OP_READY, 6'd63, 32'hFFFF_FFFF);
        push_request(OP_HEARTBEAT, 6'd0, 32'd250);
        push_request(OP_READY, 6'd0, 32'd250);
        push_request(OP_UNUSED, 6'd63, 32'hFFFF_FFFF);
        push_request(OP_SCAN, '0, 32'd2999);
        push_request(OP_SCAN, '0, 32'd3000);
        push_request(OP_SCAN, '0, 32'd3200);
        push_request(OP_SCAN, '0, 32'd3201);
        push_request(OP_HEARTBEAT, 6'd63, 32'd3300);
        push_request(OP_READY, 6'd1, 32'd3400);
        push_request(OP_HEARTBEAT, 6'd42, 32'd3400);
        push_request(OP_HEARTBEAT, 6'd21, 32'd3400);
        push_request(OP_SCAN, 6'd63, 32'd3400);
        push_request(OP_SCAN, '0, 32'd6401);
        bus_time = 32'd6401;

        foreach (phase_timeouts[p]) begin
            drain_requests();
            write_timeout(phase_timeouts[p]);
            calm = (p == 2);
            if (p == 2)
                bus_time = 32'hFFFF_0000;
            if (p == 1)
                wake_all_nodes();
            random_traffic(14);
        end
        drain_requests();
        calm = 1'b0;
        repeat (8) @(posedge i_clk);

        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ node_heartbeat_liveness_monitor_core.f @@
design/hbm_pkg.sv
design/hbm_time_ram.sv
design/node_heartbeat_liveness_monitor_core.sv
sim/testbench.sv
